// ===== src/ahct_pkg.sv =====
`timescale 1ns / 1ps
package ahct_pkg;

  localparam int unsigned HourW       = 5;
  localparam int unsigned MinuteW     = 6;
  localparam int unsigned SecondW     = 6;
  localparam int unsigned AlarmTicksW = 16;
  localparam int unsigned ChimeTicksW = 8;
  localparam int unsigned SoundsW     = 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [1:0] {
    PhaseIdle = 2'd0,
    PhaseRing = 2'd1,
    PhaseDone = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegAlarmHour      = 3'd0,
    RegAlarmMinute    = 3'd1,
    RegAlarmEnable    = 3'd2,
    RegChimeFirstHour = 3'd3,
    RegChimeLastHour  = 3'd4,
    RegChimeEnable    = 3'd5,
    RegAlarmRingTicks = 3'd6,
    RegChimeRingTicks = 3'd7
  } cfg_reg_e;

  localparam logic [HourW-1:0]       AlarmHourRst      = 5'd0;
  localparam logic [MinuteW-1:0]     AlarmMinuteRst    = 6'd0;
  localparam logic [HourW-1:0]       ChimeFirstHourRst = 5'd0;
  localparam logic [HourW-1:0]       ChimeLastHourRst  = 5'd23;
  localparam logic [AlarmTicksW-1:0] AlarmRingTicksRst = 16'd600;
  localparam logic [ChimeTicksW-1:0] ChimeRingTicksRst = 8'd5;

endpackage

// ===== src/alarm_and_hourly_chime_trigger.sv =====
`timescale 1ns / 1ps
// Alarm and hourly chime trigger. Each input transfer is one polling tick
// (hour, minute, second, key) and yields exactly one result transfer with
// buzzer, alarm ringing, chime ringing and key taken flags. The alarm and
// chime state update and the result register load in the same cycle the
// tick is accepted, unless an alarm configuration write lands with it, and a
// new tick is taken every cycle while the result register is empty or being
// drained. Configuration writes land on the cycle write enable is high;
// writing the alarm hour, minute or enable returns the alarm to idle.
// Write configuration only while no result is pending.
module alarm_and_hourly_chime_trigger (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ahct_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ahct_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ahct_pkg::HourW-1:0]          hour_now_i,
  input  logic [ahct_pkg::MinuteW-1:0]        minute_now_i,
  input  logic [ahct_pkg::SecondW-1:0]        second_now_i,
  input  logic                                key_pressed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                buzzer_on_o,
  output logic                                alarm_ringing_o,
  output logic                                chime_ringing_o,
  output logic                                key_taken_o
);
  import ahct_pkg::*;

  logic [HourW-1:0]       alarm_hour_q;
  logic [MinuteW-1:0]     alarm_minute_q;
  logic                   alarm_enable_q;
  logic [HourW-1:0]       chime_first_q;
  logic [HourW-1:0]       chime_last_q;
  logic                   chime_enable_q;
  logic [AlarmTicksW-1:0] alarm_ticks_q;
  logic [ChimeTicksW-1:0] chime_ticks_q;

  phase_e                 alarm_phase_q, alarm_phase_d;
  logic [AlarmTicksW-1:0] alarm_left_q, alarm_left_d;
  phase_e                 chime_phase_q, chime_phase_d;
  logic [ChimeTicksW-1:0] chime_left_q, chime_left_d;
  logic [SoundsW-1:0]     sounds_q, sounds_d;
  logic                   buzzer_held_q, buzzer_held_d;

  logic out_valid_q;
  logic buzzer_q, alarm_ring_q, chime_ring_q, key_taken_q;
  logic taken;
  logic in_window;
  logic in_xfer;
  logic alarm_cfg;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign alarm_cfg  = cfg_we_i && (cfg_index_i == RegAlarmHour ||
                                   cfg_index_i == RegAlarmMinute ||
                                   cfg_index_i == RegAlarmEnable);

  always_comb begin
    if (chime_first_q <= chime_last_q) begin
      in_window = (chime_first_q <= hour_now_i) && (hour_now_i <= chime_last_q);
    end else begin
      in_window = (chime_first_q <= hour_now_i) || (hour_now_i <= chime_last_q);
    end
  end

  always_comb begin
    alarm_phase_d = alarm_phase_q;
    alarm_left_d  = alarm_left_q;
    chime_phase_d = chime_phase_q;
    chime_left_d  = chime_left_q;
    sounds_d      = sounds_q;
    buzzer_held_d = buzzer_held_q;
    taken         = 1'b0;

    case (alarm_phase_q)
      PhaseIdle: begin
        if (alarm_enable_q && hour_now_i == alarm_hour_q &&
            minute_now_i == alarm_minute_q) begin
          alarm_phase_d = PhaseRing;
          alarm_left_d  = (alarm_ticks_q != '0) ? alarm_ticks_q : AlarmTicksW'(1);
          sounds_d      = sounds_d + SoundsW'(1);
        end
      end
      PhaseRing: begin
        if (key_pressed_i) begin
          alarm_phase_d = PhaseDone;
          alarm_left_d  = '0;
          sounds_d      = sounds_d - SoundsW'(1);
          taken         = 1'b1;
        end else begin
          alarm_left_d = alarm_left_q - AlarmTicksW'(1);
          if (alarm_left_d == '0) begin
            alarm_phase_d = PhaseDone;
            sounds_d      = sounds_d - SoundsW'(1);
          end
        end
      end
      default: begin
        if (hour_now_i != alarm_hour_q) begin
          alarm_phase_d = PhaseIdle;
          alarm_left_d  = '0;
        end
      end
    endcase

    if (!taken) begin
      case (chime_phase_q)
        PhaseIdle: begin
          if (chime_enable_q && minute_now_i == '0 && second_now_i == '0 &&
              in_window) begin
            chime_phase_d = PhaseRing;
            chime_left_d  = (chime_ticks_q != '0) ? chime_ticks_q : ChimeTicksW'(1);
            sounds_d      = sounds_d + SoundsW'(1);
          end
        end
        PhaseRing: begin
          chime_left_d = chime_left_q - ChimeTicksW'(1);
          if (chime_left_d == '0) begin
            chime_phase_d = PhaseDone;
            sounds_d      = sounds_d - SoundsW'(1);
          end
        end
        default: begin
          if (minute_now_i != '0) begin
            chime_phase_d = PhaseIdle;
            chime_left_d  = '0;
          end
        end
      endcase
      buzzer_held_d = (sounds_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_hour_q   <= AlarmHourRst;
      alarm_minute_q <= AlarmMinuteRst;
      alarm_enable_q <= 1'b0;
      chime_first_q  <= ChimeFirstHourRst;
      chime_last_q   <= ChimeLastHourRst;
      chime_enable_q <= 1'b0;
      alarm_ticks_q  <= AlarmRingTicksRst;
      chime_ticks_q  <= ChimeRingTicksRst;
      alarm_phase_q  <= PhaseIdle;
      alarm_left_q   <= '0;
      chime_phase_q  <= PhaseIdle;
      chime_left_q   <= '0;
      sounds_q       <= '0;
      buzzer_held_q  <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegAlarmHour:      alarm_hour_q   <= cfg_data_i[HourW-1:0];
          RegAlarmMinute:    alarm_minute_q <= cfg_data_i[MinuteW-1:0];
          RegAlarmEnable:    alarm_enable_q <= cfg_data_i[0];
          RegChimeFirstHour: chime_first_q  <= cfg_data_i[HourW-1:0];
          RegChimeLastHour:  chime_last_q   <= cfg_data_i[HourW-1:0];
          RegChimeEnable:    chime_enable_q <= cfg_data_i[0];
          RegAlarmRingTicks: alarm_ticks_q  <= cfg_data_i[AlarmTicksW-1:0];
          RegChimeRingTicks: chime_ticks_q  <= cfg_data_i[ChimeTicksW-1:0];
          default: ;
        endcase
      end
      if (alarm_cfg) begin
        if (alarm_phase_q == PhaseRing) begin
          sounds_q <= sounds_q - SoundsW'(1);
        end
        alarm_phase_q <= PhaseIdle;
        alarm_left_q  <= '0;
      end else if (in_xfer) begin
        alarm_phase_q <= alarm_phase_d;
        alarm_left_q  <= alarm_left_d;
        chime_phase_q <= chime_phase_d;
        chime_left_q  <= chime_left_d;
        sounds_q      <= sounds_d;
        buzzer_held_q <= buzzer_held_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !alarm_cfg) begin
      buzzer_q     <= buzzer_held_d;
      alarm_ring_q <= (alarm_phase_d == PhaseRing);
      chime_ring_q <= (chime_phase_d == PhaseRing);
      key_taken_q  <= taken;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign buzzer_on_o     = buzzer_q;
  assign alarm_ringing_o = alarm_ring_q;
  assign chime_ringing_o = chime_ring_q;
  assign key_taken_o     = key_taken_q;

`ifndef SYNTHESIS
  a_alarm_ring_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_phase_q == PhaseRing |-> alarm_left_q != '0)
    else $error("alarm ringing with zero ticks left");

  a_chime_ring_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chime_phase_q == PhaseRing |-> chime_left_q != '0)
    else $error("chime ringing with zero ticks left");

  a_key_silences : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !alarm_cfg && alarm_phase_q == PhaseRing && key_pressed_i)
    |=> (key_taken_o && !alarm_ringing_o && alarm_phase_q == PhaseDone))
    else $error("key press did not silence ringing alarm");

  a_taken_not_ringing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_taken_o) |-> !alarm_ringing_o)
    else $error("key taken while alarm still ringing");

  a_result_follows_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("accepted tick left no result");
`endif

endmodule
